>>> hw/rtl/ip4_pkg.sv
// Shared types and constants for the 4x4 intra predictor.
// No dependencies; used by ip4_core and intra_predictor_4x4.
package ip4_pkg;

   localparam logic [7:0] FILL_PIXEL = 8'd128;
   localparam logic [7:0] PIXEL_MAX  = 8'd255;

   // codes 6 and 7 are unused and fill the block with 128
   typedef enum logic [2:0] {
      MODE_DC         = 3'd0,
      MODE_HORIZONTAL = 3'd1,
      MODE_VERTICAL   = 3'd2,
      MODE_DIAG_DL    = 3'd3,
      MODE_DIAG_DR    = 3'd4,
      MODE_PLANAR     = 3'd5,
      MODE_FILL_LO    = 3'd6,
      MODE_FILL_HI    = 3'd7
   } mode_type;

   typedef struct packed {
      logic [2:0]  pred_mode;
      logic        above_valid;
      logic        left_valid;
      logic [31:0] above_pixels;
      logic [31:0] left_pixels;
   } req_type;

   typedef struct packed {
      logic [31:0] row_zero;
      logic [31:0] row_one;
      logic [31:0] row_two;
      logic [31:0] row_three;
   } rsp_type;

endpackage

>>> hw/rtl/ip4_core.sv
// Combinational prediction of one 4x4 block from its neighbors and mode.
// Depends on ip4_pkg.
module ip4_core
   import ip4_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   logic [7:0]  a [4];
   logic [7:0]  l [4];
   logic [7:0]  pix [4][4];
   logic [10:0] dc_sum;
   logic [7:0]  dc;
   logic [7:0]  corner;
   logic [8:0]  corner_sum;
   logic [11:0] planar_sum [4][4];
   logic [8:0]  planar_shr [4][4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a[i] = req.above_valid ? req.above_pixels[8*i +: 8] : FILL_PIXEL;
         l[i] = req.left_valid  ? req.left_pixels[8*i +: 8]  : FILL_PIXEL;
      end
   end

   // DC: rounded mean over 4 or 8 samples, or 128 when neither side is available
   always_comb begin
      dc_sum = '0;
      if (req.above_valid) begin
         dc_sum = dc_sum + 11'(a[0]) + 11'(a[1]) + 11'(a[2]) + 11'(a[3]);
      end
      if (req.left_valid) begin
         dc_sum = dc_sum + 11'(l[0]) + 11'(l[1]) + 11'(l[2]) + 11'(l[3]);
      end
      if (req.above_valid && req.left_valid) begin
         dc = 8'((dc_sum + 11'd4) >> 3);
      end else if (req.above_valid || req.left_valid) begin
         dc = 8'((dc_sum + 11'd2) >> 2);
      end else begin
         dc = FILL_PIXEL;
      end
   end

   // diagonal down-right corner: rounded mean of both sides, else the available side, else fill
   always_comb begin
      corner_sum = 9'(a[0]) + 9'(l[0]) + 9'd1;
      if (req.above_valid && req.left_valid) begin
         corner = corner_sum[8:1];
      end else if (req.above_valid) begin
         corner = a[0];
      end else if (req.left_valid) begin
         corner = l[0];
      end else begin
         corner = FILL_PIXEL;
      end
   end

   always_comb begin
      for (int y = 0; y < 4; y++) begin
         for (int x = 0; x < 4; x++) begin
            planar_sum[y][x] = 12'(a[x]) * 12'(3 - y) + 12'(l[3]) * 12'(y + 1)
                             + 12'(l[y]) * 12'(3 - x) + 12'(a[3]) * 12'(x + 1)
                             + 12'd4;
            planar_shr[y][x] = planar_sum[y][x][11:3];
         end
      end
   end

   always_comb begin
      for (int y = 0; y < 4; y++) begin
         for (int x = 0; x < 4; x++) begin
            unique case (req.pred_mode)
               MODE_DC:         pix[y][x] = dc;
               MODE_HORIZONTAL: pix[y][x] = l[y];
               MODE_VERTICAL:   pix[y][x] = a[x];
               MODE_DIAG_DL:    pix[y][x] = (x + y + 1 < 4) ? a[2'(x + y + 1)] : a[3];
               MODE_DIAG_DR: begin
                  if (x > y) begin
                     pix[y][x] = a[2'(x - y - 1)];
                  end else if (y > x) begin
                     pix[y][x] = l[2'(y - x - 1)];
                  end else begin
                     pix[y][x] = corner;
                  end
               end
               MODE_PLANAR:     pix[y][x] = planar_shr[y][x][8] ? PIXEL_MAX
                                                               : planar_shr[y][x][7:0];
               default:         pix[y][x] = FILL_PIXEL;
            endcase
         end
      end
   end

   assign rsp.row_zero  = {pix[0][3], pix[0][2], pix[0][1], pix[0][0]};
   assign rsp.row_one   = {pix[1][3], pix[1][2], pix[1][1], pix[1][0]};
   assign rsp.row_two   = {pix[2][3], pix[2][2], pix[2][1], pix[2][0]};
   assign rsp.row_three = {pix[3][3], pix[3][2], pix[3][1], pix[3][0]};

endmodule

>>> hw/rtl/intra_predictor_4x4.sv
// 4x4 intra predictor top level: input register, prediction logic, result register.
// Depends on ip4_pkg and ip4_core.
//
// Usage:
//   Drive req_data and raise start for one cycle per block; a transaction is
//   taken at each rising edge with start high and busy low. busy stays low,
//   so a new block can be issued every cycle.
//   Each block yields one result: rsp_strobe is high for exactly one cycle
//   with the four predicted rows on rsp_data.
//   An accepted block passes through the input register and then the result register,
//   with the prediction logic between them.
//   Throughput is one block per cycle, set by the single-pass logic.
//   The receiver cannot stall; results must be captured when strobed.
//   Synchronous reset drops any block in flight and clears rsp_strobe.
//   There is no configuration and no state kept across blocks.
module intra_predictor_4x4
   import ip4_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_req_ff <= req_data;
      end
      if (in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   ip4_core u_core (
      .req (in_req_ff),
      .rsp (rsp_data_in)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted block produced no result after two cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without an accepted block");

   a_fill_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(start && !busy &&
         (req_data.pred_mode == MODE_FILL_LO || req_data.pred_mode == MODE_FILL_HI), 2))
      |-> (rsp_data.row_zero == 32'h80808080 && rsp_data.row_one == 32'h80808080 &&
           rsp_data.row_two == 32'h80808080 && rsp_data.row_three == 32'h80808080))
      else $error("unused mode did not fill with 128");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for intra_predictor_4x4: directed blocks, then random ones.
// Each block's expected rows are a given golden value or come from a local predictor; all are checked in order.
// Depends on ip4_pkg and the intra_predictor_4x4 RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ip4_pkg::*;

   localparam int RANDOM_BLOCKS = 450;
   localparam int QUIET_TAIL    = 100;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   localparam rsp_type ROWS_FILL = {4{32'h8080_8080}};
   localparam rsp_type ROWS_MAX  = {4{32'hFFFF_FFFF}};
   localparam rsp_type ROWS_ZERO = '0;

   typedef struct {
      req_type blk;
      bit      has_golden;
      rsp_type golden;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // travels with req_data so the monitor picks the right expectation
   logic    golden_valid = 1'b0;
   rsp_type golden_rows = '0;

   rsp_type      expected_blocks[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;

   intra_predictor_4x4 i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic rsp_type predict_block(input req_type blk);
      logic [7:0]  above_px [4];
      logic [7:0]  left_px [4];
      logic [31:0] rows [4];
      int          sum;
      int          cnt;
      int          dc;
      int          val;
      int          k;
      rsp_type     res;
      sum = 0;
      cnt = 0;
      dc  = FILL_PIXEL;
      for (int i = 0; i < 4; i++) begin
         above_px[i] = blk.above_valid ? blk.above_pixels[8*i +: 8] : FILL_PIXEL;
         left_px[i]  = blk.left_valid ? blk.left_pixels[8*i +: 8] : FILL_PIXEL;
         rows[i]     = '0;
      end
      if (blk.above_valid) begin
         for (int i = 0; i < 4; i++) sum += above_px[i];
         cnt += 4;
      end
      if (blk.left_valid) begin
         for (int i = 0; i < 4; i++) sum += left_px[i];
         cnt += 4;
      end
      if (cnt != 0) dc = (sum + cnt / 2) / cnt;
      for (int y = 0; y < 4; y++) begin
         for (int x = 0; x < 4; x++) begin
            case (blk.pred_mode)
               MODE_DC:         val = dc;
               MODE_HORIZONTAL: val = left_px[y];
               MODE_VERTICAL:   val = above_px[x];
               MODE_DIAG_DL: begin
                  k = x + y + 1;
                  val = above_px[(k < 4) ? k : 3];
               end
               MODE_DIAG_DR: begin
                  if (x > y) val = above_px[x - y - 1];
                  else if (y > x) val = left_px[y - x - 1];
                  else if (blk.above_valid && blk.left_valid)
                     val = (int'(above_px[0]) + int'(left_px[0]) + 1) >> 1;
                  else if (blk.above_valid) val = above_px[0];
                  else if (blk.left_valid) val = left_px[0];
                  else val = FILL_PIXEL;
               end
               MODE_PLANAR: begin
                  val = (int'(above_px[x]) * (3 - y) + int'(left_px[3]) * (y + 1) +
                         int'(left_px[y]) * (3 - x) + int'(above_px[3]) * (x + 1) + 4) >> 3;
                  if (val > PIXEL_MAX) val = PIXEL_MAX;
               end
               default:         val = FILL_PIXEL;
            endcase
            rows[y][8*x +: 8] = val[7:0];
         end
      end
      res.row_zero  = rows[0];
      res.row_one   = rows[1];
      res.row_two   = rows[2];
      res.row_three = rows[3];
      return res;
   endfunction

   function automatic void add_row(input logic [2:0] mode, input logic av, input logic lv,
                                   input logic [31:0] ap, input logic [31:0] lp,
                                   input bit hg, input rsp_type g);
      stim_row_type r;
      r.blk.pred_mode    = mode;
      r.blk.above_valid  = av;
      r.blk.left_valid   = lv;
      r.blk.above_pixels = ap;
      r.blk.left_pixels  = lp;
      r.has_golden       = hg;
      r.golden           = g;
      directed_rows.push_back(r);
   endfunction

   // full random, per-byte extremes, or one repeated byte
   function automatic logic [31:0] random_pixels();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 3))
         0: for (int i = 0; i < 4; i++) w[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1: w = {4{w[7:0]}};
         default: ;
      endcase
      return w;
   endfunction

   function automatic req_type random_block();
      req_type blk;
      blk.pred_mode    = 3'($urandom_range(0, 7));
      blk.above_valid  = 1'($urandom_range(0, 1));
      blk.left_valid   = 1'($urandom_range(0, 1));
      blk.above_pixels = random_pixels();
      blk.left_pixels  = random_pixels();
      return blk;
   endfunction

   task automatic issue_block(input req_type blk, input bit has_golden, input rsp_type g);
      start        <= 1'b1;
      req_data     <= blk;
      golden_valid <= has_golden;
      golden_rows  <= g;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(input int cycles);
      start    <= 1'b0;
      req_data <= random_block();
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                  input logic [31:0] got_val);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch on %s: expected %08h, got %08h", what, exp_val, got_val);
   endtask

   always @(posedge clock) begin
      rsp_type exp_blk;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected result row_zero", '0, rsp_data.row_zero);
            end else begin
               exp_blk = expected_blocks.pop_front();
               if (rsp_data.row_zero !== exp_blk.row_zero)
                  report_mismatch("row_zero", exp_blk.row_zero, rsp_data.row_zero);
               if (rsp_data.row_one !== exp_blk.row_one)
                  report_mismatch("row_one", exp_blk.row_one, rsp_data.row_one);
               if (rsp_data.row_two !== exp_blk.row_two)
                  report_mismatch("row_two", exp_blk.row_two, rsp_data.row_two);
               if (rsp_data.row_three !== exp_blk.row_three)
                  report_mismatch("row_three", exp_blk.row_three, rsp_data.row_three);
            end
         end
         if (start && !busy)
            expected_blocks.push_back(golden_valid ? golden_rows : predict_block(req_data));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int idle_pct;
      add_row(MODE_DC, 1'b0, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 1, ROWS_FILL);
      add_row(MODE_DC, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1, ROWS_MAX);
      add_row(MODE_DC, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1, ROWS_ZERO);
      add_row(MODE_DC, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1, ROWS_FILL);
      add_row(MODE_DC, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ROWS_MAX);
      add_row(MODE_DC, 1'b1, 1'b1, 32'h0102_0304, 32'h0506_0708, 0, '0);
      add_row(MODE_HORIZONTAL, 1'b0, 1'b1, 32'h5555_5555, 32'hFF00_FF00, 1,
              {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
      add_row(MODE_HORIZONTAL, 1'b1, 1'b0, 32'h5555_5555, 32'h0000_0000, 1, ROWS_FILL);
      add_row(MODE_VERTICAL, 1'b1, 1'b0, 32'h1234_5678, 32'hFFFF_FFFF, 1, {4{32'h1234_5678}});
      add_row(MODE_VERTICAL, 1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1, ROWS_FILL);
      add_row(MODE_DIAG_DL, 1'b1, 1'b1, 32'h4433_2211, 32'hAABB_CCDD, 0, '0);
      add_row(MODE_DIAG_DL, 1'b0, 1'b1, 32'h4433_2211, 32'hAABB_CCDD, 1, ROWS_FILL);
      add_row(MODE_DIAG_DR, 1'b1, 1'b1, 32'h4433_2211, 32'h8877_66FF, 0, '0);
      add_row(MODE_DIAG_DR, 1'b1, 1'b0, 32'h4433_22FF, 32'h8877_6655, 0, '0);
      add_row(MODE_DIAG_DR, 1'b0, 1'b1, 32'h4433_2211, 32'h8877_6600, 0, '0);
      add_row(MODE_DIAG_DR, 1'b0, 1'b0, 32'h4433_2211, 32'h8877_6655, 1, ROWS_FILL);
      add_row(MODE_PLANAR, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ROWS_MAX);
      add_row(MODE_PLANAR, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1, ROWS_ZERO);
      add_row(MODE_PLANAR, 1'b1, 1'b1, 32'hFF00_00FF, 32'h00FF_FF00, 0, '0);
      add_row(MODE_PLANAR, 1'b1, 1'b0, 32'h1020_3040, 32'hFFFF_FFFF, 0, '0);
      add_row(MODE_PLANAR, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1, ROWS_FILL);
      add_row(MODE_FILL_LO, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ROWS_FILL);
      add_row(MODE_FILL_HI, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1, ROWS_FILL);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_block(directed_rows[i].blk, directed_rows[i].has_golden,
                     directed_rows[i].golden);
         if ($urandom_range(0, 99) < 30) idle_for($urandom_range(1, 17));
      end
      drain_results();

      idle_pct = 0;
      for (int n = 0; n < RANDOM_BLOCKS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 20;
               default: idle_pct = 50;
            endcase
         end
         if (n >= RANDOM_BLOCKS - QUIET_TAIL) idle_pct = 0;
         // hold off mid-run until the pipeline is empty
         if (n == RANDOM_BLOCKS / 2) drain_results();
         issue_block(random_block(), 1'b0, '0);
         if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 17));
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_blocks.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
